FILE: design/drt_pkg.sv
// Shared widths, register codes and payload types of the delayed repeat timer.
package drt_pkg;

  localparam int unsigned TIME_BITS      = 32;
  localparam int unsigned COUNT_BITS     = 16;
  localparam int unsigned ACC_BITS       = TIME_BITS + 1;
  localparam int unsigned CFG_ADDR_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS  = (TIME_BITS > COUNT_BITS) ? TIME_BITS : COUNT_BITS;
  localparam int unsigned IN_TDATA_BITS  = ((TIME_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_FIELD_BITS = 1 + ACC_BITS + 1 + COUNT_BITS;
  localparam int unsigned OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_START_DELAY  = 2'd0,
    CFG_PERIOD       = 2'd1,
    CFG_REPEAT_COUNT = 2'd2
  } cfg_addr_e;

  typedef struct packed {
    logic [TIME_BITS-1:0]  start_delay;
    logic [TIME_BITS-1:0]  period;
    logic [COUNT_BITS-1:0] repeat_count;
  } cfg_t;

  typedef struct packed {
    logic                 hold;
    logic [TIME_BITS-1:0] elapsed;
  } tick_t;

  // Packed so that fired lands in the lowest bit of the output word.
  typedef struct packed {
    logic [COUNT_BITS-1:0] fires_so_far;
    logic                  finished;
    logic [ACC_BITS-1:0]   fire_time;
    logic                  fired;
  } result_t;

endpackage

FILE: design/delayed_repeat_timer.sv
// Top level of the delayed repeat timer with its result register.
// The timer takes one tick word per clock unless the output stalls and returns one
// result word per tick, held ticks included. A tick is captured in the input register
// and its result in the result register, with the whole state update done in a single
// pass between them. Configuration registers are meant to be written while no tick is
// in flight; their writes are always accepted, as cfg_ready_o is tied high.
module delayed_repeat_timer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0: elapsed.
  input  logic [drt_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
  // Fields from bit 0: hold.
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // Fields from bit 0: fired, fire_time, finished, fires_so_far.
  output logic [drt_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [drt_pkg::CFG_ADDR_BITS-1:0]   cfg_addr_i,
  input  logic [drt_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);

  drt_pkg::cfg_t    cfg;
  drt_pkg::tick_t   tick;
  drt_pkg::result_t result, res_q;
  logic             tick_valid;
  logic             advance;
  logic             out_valid_q, out_valid_d;

  assign advance     = tick_valid && (!out_valid_q || m_axis_tready);
  assign out_valid_d = advance || (out_valid_q && !m_axis_tready);

  drt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  drt_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_user_i  (s_axis_tuser),
    .valid_o   (tick_valid),
    .ready_i   (advance),
    .tick_o    (tick)
  );

  drt_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .tick_i   (tick),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = drt_pkg::OUT_TDATA_BITS'(res_q);

endmodule

FILE: design/drt_cfg.sv
// Configuration register file of the delayed repeat timer.
module drt_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [drt_pkg::CFG_ADDR_BITS-1:0]   cfg_addr_i,
  input  logic [drt_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  output drt_pkg::cfg_t                       cfg_o
);

  drt_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        drt_pkg::CFG_START_DELAY:  cfg_d.start_delay  = cfg_data_i[drt_pkg::TIME_BITS-1:0];
        drt_pkg::CFG_PERIOD:       cfg_d.period       = cfg_data_i[drt_pkg::TIME_BITS-1:0];
        drt_pkg::CFG_REPEAT_COUNT: cfg_d.repeat_count = cfg_data_i[drt_pkg::COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: design/drt_in_reg.sv
// Input register stage that captures one tick word from the slave stream.
module drt_in_reg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_valid_i,
  output logic                                s_ready_o,
  input  logic [drt_pkg::IN_TDATA_BITS-1:0]   s_data_i,
  input  logic                                s_user_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output drt_pkg::tick_t                      tick_o
);

  logic           valid_q, valid_d;
  drt_pkg::tick_t tick_q;
  logic           load;

  assign s_ready_o = !valid_q || ready_i;
  assign load      = s_valid_i && s_ready_o;
  assign valid_d   = load || (valid_q && !ready_i);
  assign valid_o   = valid_q;
  assign tick_o    = tick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tick_q.elapsed <= s_data_i[drt_pkg::TIME_BITS-1:0];
      tick_q.hold    <= s_user_i;
    end
  end

endmodule

FILE: design/drt_core.sv
// Timer state and the single-pass tick update that produces one result.
module drt_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  drt_pkg::tick_t    tick_i,
  input  drt_pkg::cfg_t     cfg_i,
  output drt_pkg::result_t  result_o
);

  typedef enum logic [2:0] {
    PH_DELAY    = 3'd0,
    PH_EVERY    = 3'd1,
    PH_PERIODIC = 3'd2,
    PH_COUNTED  = 3'd3,
    PH_DONE     = 3'd4
  } phase_e;

  function automatic logic [drt_pkg::ACC_BITS-1:0] sat_add(
    input logic [drt_pkg::ACC_BITS-1:0] a,
    input logic [drt_pkg::ACC_BITS-1:0] b
  );
    logic [drt_pkg::ACC_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[drt_pkg::ACC_BITS] ? '1 : s[drt_pkg::ACC_BITS-1:0];
  endfunction

  phase_e                          phase_q, phase_d, mode;
  logic [drt_pkg::ACC_BITS-1:0]    delay_q, delay_d;
  logic [drt_pkg::ACC_BITS-1:0]    ia_q, ia_d, ia_cur, ia_sum;
  logic [drt_pkg::COUNT_BITS-1:0]  fc_q, fc_d, fc_cur;
  logic [drt_pkg::ACC_BITS-1:0]    dt, start_ext, period_ext;
  logic                            run;
  logic                            fired;
  logic [drt_pkg::ACC_BITS-1:0]    ftime;

  assign dt         = drt_pkg::ACC_BITS'(tick_i.elapsed);
  assign start_ext  = drt_pkg::ACC_BITS'(cfg_i.start_delay);
  assign period_ext = drt_pkg::ACC_BITS'(cfg_i.period);

  always_comb begin
    phase_d = phase_q;
    delay_d = delay_q;
    ia_d    = ia_q;
    fc_d    = fc_q;
    ia_cur  = ia_q;
    fc_cur  = fc_q;
    mode    = phase_q;
    run     = 1'b0;
    fired   = 1'b0;
    ftime   = '0;
    if (step_i && !tick_i.hold) begin
      run = 1'b1;
      if (phase_q == PH_DELAY) begin
        if (delay_q < start_ext) begin
          delay_d = sat_add(delay_q, dt);
          if (delay_d < start_ext) begin
            run = 1'b0;
          end
        end
        if (run) begin
          ia_cur = '0;
          fc_cur = '0;
          ia_d   = '0;
          fc_d   = '0;
          if (cfg_i.repeat_count != '0) begin
            mode = PH_COUNTED;
          end else if (cfg_i.period != '0) begin
            mode = PH_PERIODIC;
          end else begin
            mode = PH_EVERY;
          end
          phase_d = mode;
        end
      end
    end
    ia_sum = sat_add(ia_cur, dt);
    if (run) begin
      unique case (mode)
        PH_EVERY: begin
          fired = 1'b1;
          ftime = dt;
        end
        PH_PERIODIC: begin
          if (ia_sum >= period_ext) begin
            fired = 1'b1;
            ftime = dt;
            ia_d  = ia_sum - period_ext;
          end else begin
            ia_d  = ia_sum;
          end
        end
        PH_COUNTED: begin
          if (fc_cur >= cfg_i.repeat_count || fc_cur == '1) begin
            phase_d = PH_DONE;
          end else if (cfg_i.period == '0) begin
            fc_d  = fc_cur + drt_pkg::COUNT_BITS'(1);
            fired = 1'b1;
            ftime = dt;
          end else if (ia_sum >= period_ext) begin
            fc_d  = fc_cur + drt_pkg::COUNT_BITS'(1);
            fired = 1'b1;
            ftime = ia_sum;
            ia_d  = ia_sum - period_ext;
          end else begin
            ia_d  = ia_sum;
          end
        end
        default: ;
      endcase
    end
  end

  assign result_o.fired        = fired;
  assign result_o.fire_time    = ftime;
  assign result_o.finished     = (phase_d == PH_DONE);
  assign result_o.fires_so_far = fc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DELAY;
      delay_q <= '0;
      ia_q    <= '0;
      fc_q    <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      delay_q <= delay_d;
      ia_q    <= ia_d;
      fc_q    <= fc_d;
    end
  end

endmodule

FILE: design/drt_checker.sv
// Port-level checks of the delayed repeat timer and their binding to the top level.
module drt_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [drt_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata
);

  logic fired;
  logic finished;
  logic seen_finished_q;

  assign fired    = m_axis_tdata[0];
  assign finished = m_axis_tdata[drt_pkg::ACC_BITS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_finished_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && finished) begin
      seen_finished_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Output word changed while stalled.");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("Input stalled while the result register is empty.");

  a_no_time_without_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !fired |-> m_axis_tdata[drt_pkg::ACC_BITS:1] == '0)
    else $error("Fire time reported without a firing.");

  a_finished_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && seen_finished_q |-> finished && !fired)
    else $error("Timer left the finished state or fired after finishing.");

endmodule

bind delayed_repeat_timer drt_checker u_drt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/tb_delayed_repeat_timer.sv
// Self-checking testbench for the delayed repeat timer: directed table, random ticks, predictor.
module tb_delayed_repeat_timer;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLDOFF_CYCLES = 250;
  localparam int HOLDOFF_AFTER = 300;
  localparam int RANDOM_TICKS = 1160;
  localparam int TAIL_TICKS = 40;
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [2:0] {
    PH_DELAY    = 3'd0,
    PH_EVERY    = 3'd1,
    PH_PERIODIC = 3'd2,
    PH_COUNTED  = 3'd3,
    PH_DONE     = 3'd4
  } timer_phase_e;

  typedef enum int {MODE_EVERY, MODE_PERIODIC, MODE_COUNTED} run_mode_e;
  typedef enum int {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e                     kind;
    drt_pkg::cfg_addr_e            addr;
    logic [drt_pkg::TIME_BITS-1:0] value;
    logic                          hold;
    logic                          typed;
    drt_pkg::result_t              word;
  } stim_row_t;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               s_axis_tvalid;
  logic                               s_axis_tready;
  logic [drt_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata;
  logic                               s_axis_tuser;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready;
  logic [drt_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic                               cfg_valid_i;
  logic                               cfg_ready_o;
  logic [drt_pkg::CFG_ADDR_BITS-1:0]  cfg_addr_i;
  logic [drt_pkg::CFG_DATA_BITS-1:0]  cfg_data_i;

  drt_pkg::cfg_t                  shadow_cfg;
  timer_phase_e                   tick_phase;
  logic [drt_pkg::ACC_BITS-1:0]   delay_sum;
  logic [drt_pkg::ACC_BITS-1:0]   interval_sum;
  logic [drt_pkg::COUNT_BITS-1:0] fire_tally;

  drt_pkg::result_t results_due[$];
  stim_row_t        directed_rows[$];
  run_mode_e        run_mode;
  int               mismatches;
  bit               idle_off;
  bit               holdoff_req;

  delayed_repeat_timer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [drt_pkg::ACC_BITS-1:0] sat_add(
    logic [drt_pkg::ACC_BITS-1:0] acc,
    logic [drt_pkg::TIME_BITS-1:0] dt);
    logic [drt_pkg::ACC_BITS:0] sum;
    sum = {1'b0, acc} + {2'b00, dt};
    return sum[drt_pkg::ACC_BITS] ? '1 : sum[drt_pkg::ACC_BITS-1:0];
  endfunction

  // Advances the timer state by one tick and returns the word it produces.
  function automatic drt_pkg::result_t advance_timer(logic [drt_pkg::TIME_BITS-1:0] dt,
                                                     logic hold);
    drt_pkg::result_t word;
    logic             run;
    word = '0;
    if (!hold) begin
      run = 1'b1;
      if (tick_phase == PH_DELAY) begin
        if (delay_sum < shadow_cfg.start_delay) begin
          delay_sum = sat_add(delay_sum, dt);
          if (delay_sum < shadow_cfg.start_delay) run = 1'b0;
        end
        if (run) begin
          interval_sum = '0;
          fire_tally = '0;
          if (shadow_cfg.repeat_count != 0) tick_phase = PH_COUNTED;
          else if (shadow_cfg.period != 0) tick_phase = PH_PERIODIC;
          else tick_phase = PH_EVERY;
        end
      end
      if (run) begin
        case (tick_phase)
          PH_EVERY: begin
            word.fired = 1'b1;
            word.fire_time = drt_pkg::ACC_BITS'(dt);
          end
          PH_PERIODIC: begin
            interval_sum = sat_add(interval_sum, dt);
            if (interval_sum >= shadow_cfg.period) begin
              word.fired = 1'b1;
              word.fire_time = drt_pkg::ACC_BITS'(dt);
              interval_sum = interval_sum - shadow_cfg.period;
            end
          end
          PH_COUNTED: begin
            if (fire_tally >= shadow_cfg.repeat_count || fire_tally == '1) begin
              tick_phase = PH_DONE;
            end else if (shadow_cfg.period == 0) begin
              fire_tally++;
              word.fired = 1'b1;
              word.fire_time = drt_pkg::ACC_BITS'(dt);
            end else begin
              interval_sum = sat_add(interval_sum, dt);
              if (interval_sum >= shadow_cfg.period) begin
                fire_tally++;
                word.fired = 1'b1;
                word.fire_time = interval_sum;
                interval_sum = interval_sum - shadow_cfg.period;
              end
            end
          end
          default: ;
        endcase
      end
    end
    word.finished = (tick_phase >= PH_DONE);
    word.fires_so_far = fire_tally;
    return word;
  endfunction

  function automatic logic [drt_pkg::TIME_BITS-1:0] pick_span();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4, 5: return $urandom_range(0, 20);
      6, 7: return $urandom_range(0, 2000);
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_tick(logic [drt_pkg::TIME_BITS-1:0] dt, logic hold,
                                   logic typed, drt_pkg::result_t word);
    directed_rows.push_back('{ROW_TICK, drt_pkg::CFG_START_DELAY, dt, hold, typed, word});
  endfunction

  function automatic void add_write(drt_pkg::cfg_addr_e addr,
                                    logic [drt_pkg::TIME_BITS-1:0] value);
    directed_rows.push_back('{ROW_CFG, addr, value, 1'b0, 1'b0, '0});
  endfunction

  task automatic send_tick(input logic [drt_pkg::TIME_BITS-1:0] dt, input logic hold,
                           input logic typed, input drt_pkg::result_t word);
    drt_pkg::result_t predicted;
    if (!idle_off && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= dt;
    s_axis_tuser <= hold;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = advance_timer(dt, hold);
    results_due.push_back(typed ? word : predicted);
  endtask

  // Registers are written only once the pipeline has drained.
  task automatic write_reg(input drt_pkg::cfg_addr_e addr,
                           input logic [drt_pkg::TIME_BITS-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (addr)
      drt_pkg::CFG_START_DELAY:  shadow_cfg.start_delay = value;
      drt_pkg::CFG_PERIOD:       shadow_cfg.period = value;
      drt_pkg::CFG_REPEAT_COUNT: shadow_cfg.repeat_count = value[drt_pkg::COUNT_BITS-1:0];
      default: ;
    endcase
  endtask

  initial begin
    int                            sent;
    int                            n;
    drt_pkg::cfg_addr_e            addr;
    logic [drt_pkg::TIME_BITS-1:0] value;

    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_addr_i <= drt_pkg::CFG_START_DELAY;
    cfg_data_i <= '0;
    shadow_cfg = '0;
    tick_phase = PH_DELAY;
    delay_sum = '0;
    interval_sum = '0;
    fire_tally = '0;
    mismatches = 0;
    idle_off = 1'b0;
    holdoff_req = 1'b0;

    case ($urandom_range(0, 3))
      0: run_mode = MODE_EVERY;
      1: run_mode = MODE_PERIODIC;
      default: run_mode = MODE_COUNTED;
    endcase

    // The mode is picked once per reset, so the delay phase leads every run.
    add_tick('1, 1'b1, 1'b1, '0);
    add_write(drt_pkg::CFG_START_DELAY, 100);
    case (run_mode)
      MODE_EVERY: begin
        add_write(drt_pkg::CFG_PERIOD, 0);
        add_write(drt_pkg::CFG_REPEAT_COUNT, 0);
      end
      MODE_PERIODIC: begin
        add_write(drt_pkg::CFG_PERIOD, 7);
        add_write(drt_pkg::CFG_REPEAT_COUNT, 0);
      end
      default: begin
        add_write(drt_pkg::CFG_PERIOD, 0);
        add_write(drt_pkg::CFG_REPEAT_COUNT, 16'hFFFF);
      end
    endcase
    add_tick(0, 1'b0, 1'b1, '0);
    add_tick(60, 1'b0, 1'b1, '0);
    add_tick('1, 1'b1, 1'b1, '0);
    add_tick(39, 1'b0, 1'b1, '0);
    add_tick(1, 1'b0, 1'b0, '0);
    case (run_mode)
      MODE_EVERY: begin
        add_tick(0, 1'b0, 1'b0, '0);
        add_tick('1, 1'b0, 1'b0, '0);
        add_tick(5, 1'b1, 1'b0, '0);
        add_write(drt_pkg::CFG_PERIOD, '1);
        add_write(drt_pkg::CFG_REPEAT_COUNT, 16'hFFFF);
        add_tick(3, 1'b0, 1'b0, '0);
      end
      MODE_PERIODIC: begin
        add_tick(6, 1'b0, 1'b0, '0);
        add_tick(20, 1'b0, 1'b0, '0);
        add_tick(0, 1'b0, 1'b0, '0);
        add_tick(9, 1'b1, 1'b0, '0);
        add_write(drt_pkg::CFG_PERIOD, 1);
        repeat (3) add_tick('1, 1'b0, 1'b0, '0);
        add_tick(0, 1'b0, 1'b0, '0);
        add_write(drt_pkg::CFG_PERIOD, '1);
        add_tick('1, 1'b0, 1'b0, '0);
        add_write(drt_pkg::CFG_PERIOD, 0);
        add_tick(0, 1'b0, 1'b0, '0);
      end
      default: begin
        add_tick(0, 1'b0, 1'b0, '0);
        add_tick('1, 1'b0, 1'b0, '0);
        add_tick(4, 1'b1, 1'b0, '0);
        add_write(drt_pkg::CFG_PERIOD, 1);
        repeat (3) add_tick('1, 1'b0, 1'b0, '0);
        add_tick(0, 1'b0, 1'b0, '0);
        add_write(drt_pkg::CFG_PERIOD, '1);
        add_tick(5, 1'b0, 1'b0, '0);
        add_write(drt_pkg::CFG_PERIOD, 0);
        add_tick(2, 1'b0, 1'b0, '0);
      end
    endcase
    add_write(drt_pkg::CFG_START_DELAY, '1);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_reg(directed_rows[i].addr, directed_rows[i].value);
      end else begin
        send_tick(directed_rows[i].value, directed_rows[i].hold, directed_rows[i].typed,
                  directed_rows[i].word);
      end
    end

    sent = 0;
    while (sent < RANDOM_TICKS) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 2))
          0: addr = drt_pkg::CFG_START_DELAY;
          1: addr = drt_pkg::CFG_PERIOD;
          default: addr = drt_pkg::CFG_REPEAT_COUNT;
        endcase
        if (addr != drt_pkg::CFG_REPEAT_COUNT) begin
          value = pick_span();
        end else if (run_mode == MODE_COUNTED) begin
          // Keep the counted mode alive until the closing part of the run.
          value = ($urandom_range(0, 3) == 0) ? 16'hFFFF : $urandom_range(40000, 65535);
        end else begin
          case ($urandom_range(0, 3))
            0: value = 0;
            1: value = 16'hFFFF;
            default: value = $urandom_range(0, 65535);
          endcase
        end
        write_reg(addr, value);
      end
      n = $urandom_range(10, 100);
      // The receiver holds off while a whole batch is still being offered.
      if (sent >= HOLDOFF_AFTER) holdoff_req = 1'b1;
      repeat (n) send_tick(pick_span(), $urandom_range(0, 7) == 0, 1'b0, '0);
      sent += n;
    end

    idle_off = 1'b1;
    if (run_mode == MODE_COUNTED) begin
      write_reg(drt_pkg::CFG_REPEAT_COUNT,
                ($urandom_range(0, 1) == 0) ? '0 : drt_pkg::TIME_BITS'(fire_tally));
    end
    write_reg(drt_pkg::CFG_START_DELAY, 0);
    repeat (TAIL_TICKS) send_tick(pick_span(), $urandom_range(0, 7) == 0, 1'b0, '0);

    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    int               hold_left;
    int               burst_left;
    bit               held_off;
    drt_pkg::result_t got;
    drt_pkg::result_t want;

    hold_left = 0;
    burst_left = 0;
    held_off = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[drt_pkg::OUT_FIELD_BITS-1:0];
        if (results_due.size() == 0) begin
          $error("result word with nothing expected: %0h", got);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (got.fired !== want.fired) begin
            $error("fired: expected %0d, got %0d", want.fired, got.fired);
            mismatches++;
          end
          if (got.fire_time !== want.fire_time) begin
            $error("fire_time: expected %0h, got %0h", want.fire_time, got.fire_time);
            mismatches++;
          end
          if (got.finished !== want.finished) begin
            $error("finished: expected %0d, got %0d", want.finished, got.finished);
            mismatches++;
          end
          if (got.fires_so_far !== want.fires_so_far) begin
            $error("fires_so_far: expected %0d, got %0d", want.fires_so_far,
                   got.fires_so_far);
            mismatches++;
          end
        end
      end
      // One long hold-off lets the block fill up and push back on its input.
      if (!held_off && holdoff_req) begin
        held_off = 1'b1;
        hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        m_axis_tready <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int stalled;
    stalled = 0;
    @(posedge rst_ni);
    while (stalled < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stalled = 0;
      end else begin
        stalled++;
      end
    end
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: sim.f
design/drt_pkg.sv
design/drt_cfg.sv
design/drt_in_reg.sv
design/drt_core.sv
design/delayed_repeat_timer.sv
design/drt_checker.sv
tb/tb_delayed_repeat_timer.sv
